/* src/tps_pkg.sv */
// Shared constants and types for the trajectory point smoother.
// Used by the top level and its divide stage; depends on nothing.
package tps_pkg;

    localparam int SUBJ_W           = 10;
    localparam int META_W           = 16;
    localparam int COUNT_W          = 3;
    localparam int HIST_LEN         = 4;
    localparam int NUM_SUBJECTS_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

    typedef struct packed {
        logic [META_W-1:0] frame;
        logic [META_W-1:0] height;
    } meta_t;

endpackage

/* src/tps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package is needed.
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tps_div9.sv */
// Two-stage signed division by nine, truncating toward zero.
// Multiplies the magnitude by a scaled reciprocal in four partial products.
module tps_div9 #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS+3:0] sum,
    output logic [COORD_BITS-1:0]        quot
);

    localparam int N   = COORD_BITS + 4;
    localparam int K   = N + 4;
    localparam int RW  = N + 1;
    localparam int H   = N / 2;
    localparam int G   = RW / 2;
    localparam int PHH = (N - H) + (RW - G);
    localparam int PHL = (N - H) + G;
    localparam int PLH = H + (RW - G);
    localparam int PLL = H + G;
    localparam int PW  = N + RW;
    localparam int QW  = PW - K;

    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd8) / 64'd9);

    logic [N-1:0]   sum_u;
    logic [N-1:0]   mag;
    logic [N-H-1:0] mag_hi;
    logic [H-1:0]   mag_lo;
    logic [RW-G-1:0] rcp_hi;
    logic [G-1:0]   rcp_lo;

    logic [PHH-1:0] pp_hh_reg;
    logic [PHL-1:0] pp_hl_reg;
    logic [PLH-1:0] pp_lh_reg;
    logic [PLL-1:0] pp_ll_reg;
    logic           neg_reg;

    logic [PW-1:0]  total;
    logic [QW-1:0]  q;
    logic [QW-1:0]  q_signed;
    logic [COORD_BITS-1:0] quot_reg;

    assign sum_u  = sum;
    assign mag    = sum_u[N-1] ? (~sum_u + 1'b1) : sum_u;
    assign mag_hi = mag[N-1:H];
    assign mag_lo = mag[H-1:0];
    assign rcp_hi = RECIP[RW-1:G];
    assign rcp_lo = RECIP[G-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg   <= sum_u[N-1];
            pp_hh_reg <= PHH'(mag_hi) * PHH'(rcp_hi);
            pp_hl_reg <= PHL'(mag_hi) * PHL'(rcp_lo);
            pp_lh_reg <= PLH'(mag_lo) * PLH'(rcp_hi);
            pp_ll_reg <= PLL'(mag_lo) * PLL'(rcp_lo);
        end
    end

    assign total = (PW'(pp_hh_reg) << (H + G)) + (PW'(pp_hl_reg) << H)
                 + (PW'(pp_lh_reg) << G) + PW'(pp_ll_reg);
    assign q        = total[PW-1:K];
    assign q_signed = neg_reg ? (~q + 1'b1) : q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= q_signed[COORD_BITS-1:0];
        end
    end

    assign quot = quot_reg;

endmodule

/* src/trajectory_point_smoother_unit.sv */
// Trajectory point smoother: per-subject 5-tap weighted average of x and y.
// An input transfer passes through the input register, the weighted sums, then two stages of
// division by nine before the result is valid.
// Throughput is one point per cycle; a stalled result holds the whole pipeline and the input.
// After reset a clearing pass zeroes every subject entry, with point_stall high throughout.
// Uses tps_pkg, tps_ram and tps_div9.
module trajectory_point_smoother_unit #(
    parameter int NUM_SUBJECTS = tps_pkg::NUM_SUBJECTS_DEF,
    parameter int COORD_BITS   = tps_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          point_valid,
    output logic                          point_stall,
    input  logic [tps_pkg::SUBJ_W-1:0]    subject_id,
    input  logic [tps_pkg::META_W-1:0]    frame_number,
    input  logic signed [COORD_BITS-1:0]  pos_x,
    input  logic signed [COORD_BITS-1:0]  pos_y,
    input  logic [tps_pkg::META_W-1:0]    obj_height,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tps_pkg::SUBJ_W-1:0]    out_subject,
    output logic [tps_pkg::META_W-1:0]    out_frame,
    output logic signed [COORD_BITS-1:0]  smooth_x,
    output logic signed [COORD_BITS-1:0]  smooth_y,
    output logic [tps_pkg::META_W-1:0]    out_height
);

    localparam int AW    = $clog2(NUM_SUBJECTS);
    localparam int XW    = (AW > tps_pkg::SUBJ_W) ? AW : tps_pkg::SUBJ_W;
    localparam int SW    = COORD_BITS + 4;
    localparam int HW    = tps_pkg::HIST_LEN * COORD_BITS;
    localparam int MB    = $bits(tps_pkg::meta_t);
    localparam int X_LO  = 0;
    localparam int Y_LO  = HW;
    localparam int M0_LO = 2 * HW;
    localparam int M1_LO = M0_LO + MB;
    localparam int C_LO  = M1_LO + MB;
    localparam int EW    = C_LO + tps_pkg::COUNT_W;

    function automatic logic signed [SW-1:0] weigh(
        input logic [tps_pkg::HIST_LEN-1:0][COORD_BITS-1:0] h,
        input logic [COORD_BITS-1:0] v
    );
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] e;
        a = SW'($signed(h[0]));
        b = SW'($signed(h[1]));
        c = SW'($signed(h[2]));
        d = SW'($signed(h[3]));
        e = SW'($signed(v));
        return a + (b <<< 1) + c + (c <<< 1) + (d <<< 1) + e;
    endfunction

    logic          advance;
    logic          accept;
    logic [XW-1:0] subj_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    logic                         s1_valid_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic [tps_pkg::SUBJ_W-1:0]   s1_subj_reg;
    logic [tps_pkg::META_W-1:0]   s1_frame_reg;
    logic [tps_pkg::META_W-1:0]   s1_height_reg;
    logic [COORD_BITS-1:0]        s1_x_reg;
    logic [COORD_BITS-1:0]        s1_y_reg;

    logic          fwd_hit_reg;
    logic          fwd_hit_next;
    logic [EW-1:0] fwd_data_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic [EW-1:0]                                    cur;
    logic [tps_pkg::HIST_LEN-1:0][COORD_BITS-1:0]     cur_x;
    logic [tps_pkg::HIST_LEN-1:0][COORD_BITS-1:0]     cur_y;
    logic [tps_pkg::HIST_LEN-1:0][COORD_BITS-1:0]     new_x;
    logic [tps_pkg::HIST_LEN-1:0][COORD_BITS-1:0]     new_y;
    tps_pkg::meta_t                                   meta0;
    tps_pkg::meta_t                                   meta1;
    tps_pkg::meta_t                                   meta_in;
    logic [tps_pkg::COUNT_W-1:0]                      count;
    logic [tps_pkg::COUNT_W-1:0]                      new_count;
    logic                                             full;
    logic [EW-1:0]                                    item_wdata;

    logic                         s2_valid_reg;
    logic                         s2_valid_next;
    logic [tps_pkg::SUBJ_W-1:0]   s2_subj_reg;
    tps_pkg::meta_t               s2_meta_reg;
    logic signed [SW-1:0]         s2_sum_x_reg;
    logic signed [SW-1:0]         s2_sum_y_reg;

    logic                         s3_valid_reg;
    logic [tps_pkg::SUBJ_W-1:0]   s3_subj_reg;
    tps_pkg::meta_t               s3_meta_reg;

    logic                         result_valid_reg;
    logic [tps_pkg::SUBJ_W-1:0]   out_subject_reg;
    tps_pkg::meta_t               out_meta_reg;

    assign advance     = !result_valid_reg || !result_stall;
    assign point_stall = clearing_reg || !advance;
    assign accept      = point_valid && !point_stall;

    assign subj_ext = XW'(subject_id);
    assign in_addr  = subj_ext[AW-1:0];
    assign in_range = 32'(subject_id) < 32'(NUM_SUBJECTS);

    // Clearing pass over every subject entry after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(NUM_SUBJECTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg   <= in_addr;
            s1_subj_reg   <= subject_id;
            s1_frame_reg  <= frame_number;
            s1_height_reg <= obj_height;
            s1_x_reg      <= pos_x;
            s1_y_reg      <= pos_y;
        end
    end

    // Read-modify-write of the subject entry, with forwarding of a same-edge write.
    assign cur       = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign cur_x     = cur[X_LO +: HW];
    assign cur_y     = cur[Y_LO +: HW];
    assign meta0     = cur[M0_LO +: MB];
    assign meta1     = cur[M1_LO +: MB];
    assign count     = cur[C_LO +: tps_pkg::COUNT_W];
    assign full      = count >= tps_pkg::COUNT_FULL;
    assign new_count = full ? count : count + 1'b1;
    assign new_x     = {s1_x_reg, cur_x[3], cur_x[2], cur_x[1]};
    assign new_y     = {s1_y_reg, cur_y[3], cur_y[2], cur_y[1]};

    always_comb
    begin
        meta_in.frame  = s1_frame_reg;
        meta_in.height = s1_height_reg;
    end

    assign item_wdata = {new_count, meta_in, meta1, new_y, new_x};

    assign ram_we    = clearing_reg || (advance && s1_valid_reg);
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : item_wdata;

    assign fwd_hit_next = s1_valid_reg && (s1_addr_reg == in_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_data_reg <= item_wdata;
        end
    end

    tps_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SUBJECTS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Weighted sums of the five points.
    assign s2_valid_next = s1_valid_reg && full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg     <= s2_valid_next;
            s3_valid_reg     <= s2_valid_reg;
            result_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_subj_reg     <= s1_subj_reg;
            s2_meta_reg     <= meta0;
            s2_sum_x_reg    <= weigh(cur_x, s1_x_reg);
            s2_sum_y_reg    <= weigh(cur_y, s1_y_reg);
            s3_subj_reg     <= s2_subj_reg;
            s3_meta_reg     <= s2_meta_reg;
            out_subject_reg <= s3_subj_reg;
            out_meta_reg    <= s3_meta_reg;
        end
    end

    tps_div9 #(
        .COORD_BITS (COORD_BITS)
    ) u_div_x (
        .clk  (clk),
        .en   (advance),
        .sum  (s2_sum_x_reg),
        .quot (smooth_x)
    );

    tps_div9 #(
        .COORD_BITS (COORD_BITS)
    ) u_div_y (
        .clk  (clk),
        .en   (advance),
        .sum  (s2_sum_y_reg),
        .quot (smooth_y)
    );

    assign result_valid = result_valid_reg;
    assign out_subject  = out_subject_reg;
    assign out_frame    = out_meta_reg.frame;
    assign out_height   = out_meta_reg.height;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for trajectory_point_smoother_unit: a directed table, then random
// tracks under sender and receiver idling, each result checked against a typed value or a per-subject predictor.
// Depends on tps_pkg and the smoother RTL.
module testbench;

    localparam int NUM_SUBJ    = tps_pkg::NUM_SUBJECTS_DEF;
    localparam int CW          = tps_pkg::COORD_BITS_DEF;
    localparam int SUBJ_W      = tps_pkg::SUBJ_W;
    localparam int META_W      = tps_pkg::META_W;
    localparam int HIST_LEN    = tps_pkg::HIST_LEN;
    localparam int COUNT_W     = tps_pkg::COUNT_W;
    localparam int HALF_PERIOD = 6;
    localparam int HOLD_LEN    = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int POOL_SIZE   = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [SUBJ_W-1:0]    subject;
        logic [META_W-1:0]    frame;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [META_W-1:0]    height;
    } track_pt_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_EXPECT} row_kind_t;

    typedef struct {
        row_kind_t kind;
        track_pt_t pt;
        track_pt_t res;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 point_valid;
    logic                 point_stall;
    logic [SUBJ_W-1:0]    subject_id;
    logic [META_W-1:0]    frame_number;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [META_W-1:0]    obj_height;
    logic                 result_valid;
    logic                 result_stall;
    logic [SUBJ_W-1:0]    out_subject;
    logic [META_W-1:0]    out_frame;
    logic signed [CW-1:0] smooth_x;
    logic signed [CW-1:0] smooth_y;
    logic [META_W-1:0]    out_height;

    logic signed [CW-1:0] x_hist [NUM_SUBJ][HIST_LEN];
    logic signed [CW-1:0] y_hist [NUM_SUBJ][HIST_LEN];
    tps_pkg::meta_t       centre [NUM_SUBJ][2];
    logic [COUNT_W-1:0]   seen   [NUM_SUBJ];

    track_pt_t            smoothed_q [$];
    track_pt_t            want;
    row_t                 steps [$];
    int                   errors = 0;
    int                   cycle_count = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    bit                   hold_req = 1'b0;
    int                   hold_cnt = 0;

    trajectory_point_smoother_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .subject_id   (subject_id),
        .frame_number (frame_number),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .obj_height   (obj_height),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_subject  (out_subject),
        .out_frame    (out_frame),
        .smooth_x     (smooth_x),
        .smooth_y     (smooth_y),
        .out_height   (out_height)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit track_update(input track_pt_t p, output track_pt_t r);
        int s;
        int sx;
        int sy;
        bit produced;
        s = p.subject;
        produced = (seen[s] >= tps_pkg::COUNT_FULL);
        sx = int'(x_hist[s][0]) + 2 * int'(x_hist[s][1]) + 3 * int'(x_hist[s][2])
             + 2 * int'(x_hist[s][3]) + int'(p.x);
        sy = int'(y_hist[s][0]) + 2 * int'(y_hist[s][1]) + 3 * int'(y_hist[s][2])
             + 2 * int'(y_hist[s][3]) + int'(p.y);
        r = '0;
        if (produced)
        begin
            r.subject = p.subject;
            r.frame   = centre[s][0].frame;
            r.x       = CW'(sx / 9);
            r.y       = CW'(sy / 9);
            r.height  = centre[s][0].height;
        end
        for (int i = 0; i < HIST_LEN - 1; i++)
        begin
            x_hist[s][i] = x_hist[s][i + 1];
            y_hist[s][i] = y_hist[s][i + 1];
        end
        x_hist[s][HIST_LEN - 1] = p.x;
        y_hist[s][HIST_LEN - 1] = p.y;
        centre[s][0]        = centre[s][1];
        centre[s][1].frame  = p.frame;
        centre[s][1].height = p.height;
        if (seen[s] < tps_pkg::COUNT_FULL)
            seen[s] = seen[s] + 1'b1;
        return produced;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = CW'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sh7FFE;
                    default: v = 16'sh8001;
                endcase
            end
            default: v = CW'(int'($urandom_range(0, 200)) - 100);
        endcase
        return v;
    endfunction

    task automatic add_row(input row_kind_t kind, input int subj, input int frame,
                           input int x, input int y, input int h,
                           input int ef, input int ex, input int ey, input int eh);
        row_t r;
        r.kind       = kind;
        r.pt.subject = SUBJ_W'(subj);
        r.pt.frame   = META_W'(frame);
        r.pt.x       = CW'(x);
        r.pt.y       = CW'(y);
        r.pt.height  = META_W'(h);
        r.res.subject = SUBJ_W'(subj);
        r.res.frame   = META_W'(ef);
        r.res.x       = CW'(ex);
        r.res.y       = CW'(ey);
        r.res.height  = META_W'(eh);
        steps = {steps, r};
    endtask

    task automatic send_point(input track_pt_t p, input row_kind_t kind, input track_pt_t typed);
        track_pt_t r;
        bit produced;
        point_valid  <= 1'b1;
        subject_id   <= p.subject;
        frame_number <= p.frame;
        pos_x        <= p.x;
        pos_y        <= p.y;
        obj_height   <= p.height;
        do
            @(negedge clk);
        while (point_stall);
        @(posedge clk);
        produced = track_update(p, r);
        if (kind == ROW_PREDICT && produced)
            smoothed_q = {smoothed_q, r};
        else if (kind == ROW_EXPECT)
            smoothed_q = {smoothed_q, typed};
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        point_valid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input bit hold);
        int pool [POOL_SIZE];
        int last_subj;
        track_pt_t p;
        track_pt_t none;
        none = '0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        hold_req    = hold;
        foreach (pool[i])
            pool[i] = $urandom_range(0, NUM_SUBJ - 1);
        last_subj = pool[0];
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: p.subject = SUBJ_W'($urandom);
                2, 3, 4: p.subject = SUBJ_W'(last_subj);
                default: p.subject = SUBJ_W'(pool[$urandom_range(0, POOL_SIZE - 1)]);
            endcase
            last_subj = p.subject;
            p.frame  = META_W'($urandom);
            p.x      = rand_coord();
            p.y      = rand_coord();
            p.height = META_W'($urandom);
            send_point(p, ROW_PREDICT, none);
        end
        drain_results();
        hold_req = 1'b0;
    endtask

    task automatic check_field(input string name, input int e, input int a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (smoothed_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual subject %0d frame %0d",
                         $time, out_subject, out_frame);
                errors++;
            end
            else
            begin
                want = smoothed_q.pop_front();
                check_field("out_subject", want.subject, out_subject);
                check_field("out_frame", want.frame, out_frame);
                check_field("smooth_x", want.x, smooth_x);
                check_field("smooth_y", want.y, smooth_y);
                check_field("out_height", want.height, out_height);
            end
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_cnt < HOLD_LEN)
            begin
                hold_cnt++;
                result_stall <= 1'b1;
            end
            else
            begin
                if (!hold_req)
                    hold_cnt = 0;
                result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    initial
    begin
        foreach (seen[i])
            seen[i] = '0;
        rst_n        = 1'b0;
        point_valid  = 1'b0;
        subject_id   = '0;
        frame_number = '0;
        pos_x        = '0;
        pos_y        = '0;
        obj_height   = '0;

        // Two full tracks at opposite coordinate extremes, interleaved, then a saturated point.
        add_row(ROW_NONE,      0,   100,  32767, -32768,      0,     0,      0,      0,      0);
        add_row(ROW_NONE,   1023, 65531, -32768,  32767,  65535,     0,      0,      0,      0);
        add_row(ROW_NONE,      0,   101,  32767, -32768,  65535,     0,      0,      0,      0);
        add_row(ROW_NONE,   1023, 65532, -32768,  32767,      0,     0,      0,      0,      0);
        add_row(ROW_NONE,      0,   102,  32767, -32768, 'hA5A5,     0,      0,      0,      0);
        add_row(ROW_NONE,   1023, 65533, -32768,  32767, 'h5A5A,     0,      0,      0,      0);
        add_row(ROW_NONE,      0,   103,  32767, -32768,      0,     0,      0,      0,      0);
        add_row(ROW_NONE,   1023, 65534, -32768,  32767,  65535,     0,      0,      0,      0);
        add_row(ROW_EXPECT,    0,   104,  32767, -32768,  65535,   102,  32767, -32768, 'hA5A5);
        add_row(ROW_EXPECT, 1023, 65535, -32768,  32767,      0, 65533, -32768,  32767, 'h5A5A);
        add_row(ROW_PREDICT,   0,   105, -32768,  32767, 'h1234,     0,      0,      0,      0);
        // Small negative sums, where truncation toward zero differs from flooring.
        add_row(ROW_NONE,      5,     0,     -1,      1,      1,     0,      0,      0,      0);
        add_row(ROW_NONE,      5,     1,      0,     -2,      2,     0,      0,      0,      0);
        add_row(ROW_NONE,      5,     2,      0,      0,      3,     0,      0,      0,      0);
        add_row(ROW_NONE,      5,     3,      0,      0,      4,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   5,     4,      0,     -1,      5,     0,      0,      0,      0);
        // Back-to-back points of one subject.
        add_row(ROW_PREDICT,   7,    10,    100,    -50,     10,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   7,    11,   -200,     75,     11,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   7,    12,    300,    -90,     12,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   7,    13,   -400,     33,     13,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   7,    14,    500,    -17,     14,     0,      0,      0,      0);
        add_row(ROW_PREDICT,   7,    15,   -600,      8,     15,     0,      0,      0,      0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send_point(steps[i].pt, steps[i].kind, steps[i].res);
        drain_results();

        run_phase(33, 45, 143, 1'b0);
        run_phase(45, 33, 143, 1'b0);
        run_phase(0, 0, 143, 1'b1);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/tps_pkg.sv
src/tps_ram.sv
src/tps_div9.sv
src/trajectory_point_smoother_unit.sv
dv/testbench.sv
